// File: hw/rtl/ucfd_pkg.sv
// Package for the serial command frame decoder: frame constants, car state
// codes, controller states and the command/status structs.
// No dependencies.
package ucfd_pkg;

    // Frame markers
    localparam logic [7:0] HDR_FIRST   = 8'hFF;
    localparam logic [7:0] HDR_SECOND  = 8'hAA;
    localparam logic [7:0] TRL_FIRST   = 8'hFE;
    localparam logic [7:0] TRL_SECOND  = 8'hEF;
    localparam logic [7:0] MAX_LEN     = 8'd4;

    // Command types (frame byte 2)
    localparam logic [7:0] CMD_POWER    = 8'h01;
    localparam logic [7:0] CMD_MOTION   = 8'h02;
    localparam logic [7:0] CMD_MODE     = 8'h03;
    localparam logic [7:0] CMD_SPEED    = 8'h04;
    localparam logic [7:0] CMD_DISTANCE = 8'h05;
    localparam logic [7:0] CMD_ANGLE    = 8'h06;

    // Data codes
    localparam logic [7:0] PWR_ON      = 8'h01;
    localparam logic [7:0] PWR_OFF     = 8'h02;
    localparam logic [7:0] MOV_FRONT   = 8'h01;
    localparam logic [7:0] MOV_RIGHT   = 8'h02;
    localparam logic [7:0] MOV_STOP    = 8'h03;
    localparam logic [7:0] MOV_LEFT    = 8'h04;
    localparam logic [7:0] MOV_BACK    = 8'h05;
    localparam logic [7:0] MODE_AUTO   = 8'h01;
    localparam logic [7:0] MODE_LINE   = 8'h02;

    // Motor pin codes, bit1 IN1, bit0 IN2
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_FWD  = 2'd2;

    // Reset values of the settings
    localparam logic [7:0] SPEED_RST    = 8'd70;
    localparam logic [7:0] DISTANCE_RST = 8'd20;
    localparam logic [7:0] ANGLE_RST    = 8'd30;

    localparam int WIN_BYTES = 8;

    typedef enum logic [3:0] {
        ST_FREE     = 4'd0,
        ST_ON       = 4'd1,
        ST_OFF      = 4'd2,
        ST_FRONT    = 4'd3,
        ST_BACK     = 4'd4,
        ST_RIGHT    = 4'd5,
        ST_LEFT     = 4'd6,
        ST_STOP     = 4'd7,
        ST_AUTO     = 4'd8,
        ST_LINE     = 4'd9,
        ST_SPEED    = 4'd10,
        ST_DISTANCE = 4'd11,
        ST_ANGLE    = 4'd12
    } car_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_DECODE
    } ucfd_fsm_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // shift in the accepted word, restart the search
        logic search;  // test the current rotation, rotate on a miss
        logic commit;  // update held state and the result register
    } ucfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;     // header pair at the front of the current rotation
    } ucfd_status_t;

endpackage

// File: hw/rtl/ucfd_ctrl.sv
// Controller of the frame decoder: idle/search/decode state machine,
// rotation counter and result valid flag. Depends on ucfd_pkg.
module ucfd_ctrl
    import ucfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  ucfd_status_t status,
    output ucfd_cmd_t    cmd
);

    ucfd_fsm_t  state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                if (status.hit || step_reg == 3'(WIN_BYTES - 1)) begin
                    state_next = FSM_DECODE;
                end
            end
            FSM_DECODE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            FSM_SEARCH: begin
                cmd.search = 1'b1;
            end
            FSM_DECODE: begin
                cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Rotation counter and result valid
    always_comb begin
        step_next = step_reg;
        if (cmd.load) begin
            step_next = '0;
        end else if (cmd.search) begin
            step_next = step_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: hw/rtl/ucfd_dp.sv
// Datapath of the frame decoder: byte window, rotating search copy, command
// decode and held car state. Depends on ucfd_pkg.
module ucfd_dp
    import ucfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ucfd_cmd_t    cmd,
    output ucfd_status_t status,
    input  logic [7:0]   rx_byte,
    output logic         frame_found,
    output logic [3:0]   car_state,
    output logic [1:0]   motor_a_dir,
    output logic [1:0]   motor_b_dir,
    output logic [7:0]   pwm_duty,
    output logic         pwm_running,
    output logic [63:0]  echo_frame,
    output logic [7:0]   speed_value,
    output logic [7:0]   distance_value,
    output logic [7:0]   angle_value
);

    // Window holds the oldest byte in the top bits
    logic [63:0] win_reg, win_next;
    logic [63:0] work_reg, work_next;
    logic        found_reg, found_next;
    logic        res_found_reg;
    logic [63:0] res_echo_reg;

    car_state_t  held_reg, held_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  dist_reg, dist_next;
    logic [7:0]  angle_reg, angle_next;
    logic [1:0]  dir_a_reg, dir_a_next;
    logic [1:0]  dir_b_reg, dir_b_next;
    logic [7:0]  duty_reg, duty_next;
    logic        pwm_en_reg, pwm_en_next;

    logic [7:0]  fb [WIN_BYTES];
    logic [7:0]  f_cmd, f_len, d_byte;
    logic        frame_ok, done;

    // Split the current rotation into bytes, byte 0 first
    always_comb begin
        for (int j = 0; j < WIN_BYTES; j++) begin
            fb[j] = work_reg[63 - 8 * j -: 8];
        end
    end

    assign status.hit = (fb[0] == HDR_FIRST) && (fb[1] == HDR_SECOND);
    assign f_cmd      = fb[2];
    assign f_len      = fb[3];
    assign frame_ok   = (fb[6] == TRL_FIRST) && (fb[7] == TRL_SECOND) && (f_len <= MAX_LEN);

    // Window shift, search copy and found flag
    always_comb begin
        win_next   = win_reg;
        work_next  = work_reg;
        found_next = found_reg;
        if (cmd.load) begin
            win_next   = {win_reg[55:0], rx_byte};
            work_next  = {win_reg[55:0], rx_byte};
            found_next = 1'b0;
        end else if (cmd.search) begin
            if (status.hit) begin
                found_next = 1'b1;
            end else begin
                work_next = {work_reg[55:0], work_reg[63:56]};
            end
        end
    end

    // Decode the aligned frame into the next held state
    always_comb begin
        held_next   = held_reg;
        speed_next  = speed_reg;
        dist_next   = dist_reg;
        angle_next  = angle_reg;
        dir_a_next  = dir_a_reg;
        dir_b_next  = dir_b_reg;
        duty_next   = duty_reg;
        pwm_en_next = pwm_en_reg;
        done        = 1'b0;
        d_byte      = '0;
        if (found_reg) begin
            if (!frame_ok) begin
                duty_next = '0;
                held_next = ST_FREE;
            end else begin
                held_next = ST_FREE;
                // Scan the data bytes in order, first known code acts
                for (int k = 0; k < 4; k++) begin
                    if (!done && (8'(k) < f_len)) begin
                        d_byte = fb[4 + k];
                        unique case (f_cmd)
                            CMD_POWER: begin
                                if (d_byte == PWR_ON) begin
                                    pwm_en_next = 1'b1;
                                    held_next   = ST_ON;
                                    done        = 1'b1;
                                end else if (d_byte == PWR_OFF) begin
                                    pwm_en_next = 1'b0;
                                    held_next   = ST_OFF;
                                    done        = 1'b1;
                                end
                            end
                            CMD_MOTION: begin
                                if (d_byte == MOV_FRONT) begin
                                    dir_a_next = DIR_FWD;
                                    dir_b_next = DIR_FWD;
                                    duty_next  = speed_reg;
                                    held_next  = ST_FRONT;
                                    done       = 1'b1;
                                end else if (d_byte == MOV_RIGHT) begin
                                    dir_a_next = DIR_FWD;
                                    dir_b_next = DIR_REV;
                                    duty_next  = speed_reg;
                                    held_next  = ST_RIGHT;
                                    done       = 1'b1;
                                end else if (d_byte == MOV_STOP) begin
                                    dir_a_next = DIR_FWD;
                                    dir_b_next = DIR_FWD;
                                    duty_next  = '0;
                                    held_next  = ST_STOP;
                                    done       = 1'b1;
                                end else if (d_byte == MOV_LEFT) begin
                                    dir_a_next = DIR_REV;
                                    dir_b_next = DIR_FWD;
                                    duty_next  = speed_reg;
                                    held_next  = ST_LEFT;
                                    done       = 1'b1;
                                end else if (d_byte == MOV_BACK) begin
                                    dir_a_next = DIR_REV;
                                    dir_b_next = DIR_REV;
                                    duty_next  = speed_reg;
                                    held_next  = ST_BACK;
                                    done       = 1'b1;
                                end
                            end
                            CMD_MODE: begin
                                if (d_byte == MODE_AUTO) begin
                                    held_next = ST_AUTO;
                                    done      = 1'b1;
                                end else if (d_byte == MODE_LINE) begin
                                    held_next = ST_LINE;
                                    done      = 1'b1;
                                end
                            end
                            default: begin
                                done = done;
                            end
                        endcase
                    end
                end
                // Setting commands store the first data byte
                if (!done && (f_len != 8'd0)) begin
                    unique case (f_cmd)
                        CMD_SPEED: begin
                            speed_next = fb[4];
                            held_next  = ST_SPEED;
                        end
                        CMD_DISTANCE: begin
                            dist_next = fb[4];
                            held_next = ST_DISTANCE;
                        end
                        CMD_ANGLE: begin
                            angle_next = fb[4];
                            held_next  = ST_ANGLE;
                        end
                        default: begin
                            held_next = ST_FREE;
                        end
                    endcase
                end
            end
        end
    end

    // Window and search registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            win_reg   <= win_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    // Held state, updated on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= ST_FREE;
            speed_reg  <= SPEED_RST;
            dist_reg   <= DISTANCE_RST;
            angle_reg  <= ANGLE_RST;
            dir_a_reg  <= DIR_IDLE;
            dir_b_reg  <= DIR_IDLE;
            duty_reg   <= '0;
            pwm_en_reg <= 1'b0;
        end else if (cmd.commit) begin
            held_reg   <= held_next;
            speed_reg  <= speed_next;
            dist_reg   <= dist_next;
            angle_reg  <= angle_next;
            dir_a_reg  <= dir_a_next;
            dir_b_reg  <= dir_b_next;
            duty_reg   <= duty_next;
            pwm_en_reg <= pwm_en_next;
        end
    end

    // Result register for the per-word fields
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_found_reg <= found_reg;
            res_echo_reg  <= found_reg ? work_reg : 64'd0;
        end
    end

    assign frame_found    = res_found_reg;
    assign echo_frame     = res_echo_reg;
    assign car_state      = held_reg;
    assign motor_a_dir    = dir_a_reg;
    assign motor_b_dir    = dir_b_reg;
    assign pwm_duty       = duty_reg;
    assign pwm_running    = pwm_en_reg;
    assign speed_value    = speed_reg;
    assign distance_value = dist_reg;
    assign angle_value    = angle_reg;

endmodule

// File: hw/rtl/uart_command_frame_decoder_unit.sv
// Top level of the serial command frame decoder: controller plus datapath.
// Depends on ucfd_pkg, ucfd_ctrl and ucfd_dp.
//
// Usage:
//   Input channel s_valid/s_ready carries one received byte per word on
//   s_rx_byte. Each accepted word produces exactly one result word on the
//   m_ channel: frame_found and echo_frame for this byte, plus the held car
//   state, motor pins, PWM duty/enable and the three stored settings.
// Sequence:
//   A word is accepted in idle, then searched (one window rotation per
//   cycle until the header pair is at the front or all rotations are
//   tried), then decoded into the result register, which raises m_valid.
//   The next word is taken as soon as the controller is back in idle.
// Reset (aresetn low, synchronous): window cleared, state free, speed 70,
//   distance 20, angle 30, motors and PWM off, no result pending.
// Stall: a result not yet taken holds on the m_ ports; a new byte is still
//   accepted and searched, and its decode waits until the result register
//   is taken.
module uart_command_frame_decoder_unit
    import ucfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_found,
    output logic [3:0]  m_car_state,
    output logic [1:0]  m_motor_a_dir,
    output logic [1:0]  m_motor_b_dir,
    output logic [7:0]  m_pwm_duty,
    output logic        m_pwm_running,
    output logic [63:0] m_echo_frame,
    output logic [7:0]  m_speed_value,
    output logic [7:0]  m_distance_value,
    output logic [7:0]  m_angle_value
);

    ucfd_cmd_t    cmd;
    ucfd_status_t status;

    ucfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ucfd_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .rx_byte        (s_rx_byte),
        .frame_found    (m_frame_found),
        .car_state      (m_car_state),
        .motor_a_dir    (m_motor_a_dir),
        .motor_b_dir    (m_motor_b_dir),
        .pwm_duty       (m_pwm_duty),
        .pwm_running    (m_pwm_running),
        .echo_frame     (m_echo_frame),
        .speed_value    (m_speed_value),
        .distance_value (m_distance_value),
        .angle_value    (m_angle_value)
    );

endmodule

// File: tb/uart_command_frame_decoder_unit_tb.sv
// Self-checking testbench for the serial command frame decoder unit.
// Depends on ucfd_pkg and the RTL of uart_command_frame_decoder_unit.
// Drives directed and random received bytes, predicts every status word.
module uart_command_frame_decoder_unit_tb;
    import ucfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DIRECTED_ROWS = 24;
    localparam int  RANDOM_BYTES  = 1600;
    localparam int  CYCLE_LIMIT   = 500000;
    localparam int  HOLDOFF_AT    = 600;
    localparam int  HOLDOFF_LEN   = 300;
    localparam int  QUIET_FROM    = 1000;
    localparam int  QUIET_TO      = 1250;
    localparam int  DRAIN_CYCLES  = 24;
    localparam int  PRINT_CAP     = 30;

    // Directed bytes: power on frame, speed 255 frame, move front frame
    localparam logic [7:0] DIRECTED_RX [0:DIRECTED_ROWS-1] = '{
        8'hFF, 8'hAA, 8'h01, 8'h01, 8'h01, 8'h00, 8'hFE, 8'hEF,
        8'hFF, 8'hAA, 8'h04, 8'h01, 8'hFF, 8'h00, 8'hFE, 8'hEF,
        8'hFF, 8'hAA, 8'h02, 8'h01, 8'h01, 8'h00, 8'hFE, 8'hEF
    };

    typedef struct {
        logic        found;
        car_state_t  state;
        logic [1:0]  dir_a;
        logic [1:0]  dir_b;
        logic [7:0]  duty;
        logic        run;
        logic [63:0] echo;
        logic [7:0]  speed;
        logic [7:0]  distance;
        logic [7:0]  angle;
    } status_word_t;

    typedef struct {
        logic [7:0]   rx;
        bit           typed;
        status_word_t want;
    } rx_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_frame_found;
    logic [3:0]  m_car_state;
    logic [1:0]  m_motor_a_dir;
    logic [1:0]  m_motor_b_dir;
    logic [7:0]  m_pwm_duty;
    logic        m_pwm_running;
    logic [63:0] m_echo_frame;
    logic [7:0]  m_speed_value;
    logic [7:0]  m_distance_value;
    logic [7:0]  m_angle_value;

    // Predicted decoder state
    logic [7:0]  win_mem [0:7];
    logic [2:0]  win_ptr;
    car_state_t  held_car;
    logic [7:0]  set_speed;
    logic [7:0]  set_dist;
    logic [7:0]  set_angle;
    logic [1:0]  pin_a;
    logic [1:0]  pin_b;
    logic [7:0]  duty_q;
    logic        run_q;

    rx_row_t      rx_plan [$];
    status_word_t status_queue [$];

    int          accepted_bytes = 0;
    int          checked_words  = 0;
    int          found_words    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic [15:0] states_seen    = '0;

    uart_command_frame_decoder_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_found    (m_frame_found),
        .m_car_state      (m_car_state),
        .m_motor_a_dir    (m_motor_a_dir),
        .m_motor_b_dir    (m_motor_b_dir),
        .m_pwm_duty       (m_pwm_duty),
        .m_pwm_running    (m_pwm_running),
        .m_echo_frame     (m_echo_frame),
        .m_speed_value    (m_speed_value),
        .m_distance_value (m_distance_value),
        .m_angle_value    (m_angle_value)
    );

    always #6 aclk = ~aclk;

    function automatic bit in_quiet_stretch();
        return accepted_bytes >= QUIET_FROM && accepted_bytes < QUIET_TO;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [63:0] f, input int k);
        return f[63-8*k -: 8];
    endfunction

    // Decode an aligned frame; update the predicted motor, PWM and settings
    function automatic car_state_t decode_command(input logic [63:0] f);
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] d;
        int         k;
        cmd = frame_byte(f, 2);
        len = frame_byte(f, 3);
        if (frame_byte(f, 6) != TRL_FIRST || frame_byte(f, 7) != TRL_SECOND
            || len > MAX_LEN) begin
            duty_q = 8'd0;
            return ST_FREE;
        end
        // Scan data bytes in order; first known code wins
        for (k = 0; k < int'(len); k++) begin
            d = frame_byte(f, 4 + k);
            case (cmd)
                CMD_POWER: begin
                    if (d == PWR_ON) begin run_q = 1'b1; return ST_ON; end
                    if (d == PWR_OFF) begin run_q = 1'b0; return ST_OFF; end
                end
                CMD_MOTION: begin
                    if (d == MOV_FRONT) begin
                        pin_a = DIR_FWD; pin_b = DIR_FWD; duty_q = set_speed;
                        return ST_FRONT;
                    end
                    if (d == MOV_RIGHT) begin
                        pin_a = DIR_FWD; pin_b = DIR_REV; duty_q = set_speed;
                        return ST_RIGHT;
                    end
                    if (d == MOV_STOP) begin
                        pin_a = DIR_FWD; pin_b = DIR_FWD; duty_q = 8'd0;
                        return ST_STOP;
                    end
                    if (d == MOV_LEFT) begin
                        pin_a = DIR_REV; pin_b = DIR_FWD; duty_q = set_speed;
                        return ST_LEFT;
                    end
                    if (d == MOV_BACK) begin
                        pin_a = DIR_REV; pin_b = DIR_REV; duty_q = set_speed;
                        return ST_BACK;
                    end
                end
                CMD_MODE: begin
                    if (d == MODE_AUTO) return ST_AUTO;
                    if (d == MODE_LINE) return ST_LINE;
                end
                default: break;
            endcase
        end
        // Settings take frame byte 4, the first data byte, when there is at least one data byte
        if (len >= 8'd1) begin
            if (cmd == CMD_SPEED) begin set_speed = frame_byte(f, 4); return ST_SPEED; end
            if (cmd == CMD_DISTANCE) begin
                set_dist = frame_byte(f, 4);
                return ST_DISTANCE;
            end
            if (cmd == CMD_ANGLE) begin set_angle = frame_byte(f, 4); return ST_ANGLE; end
        end
        return ST_FREE;
    endfunction

    // Shift a byte into the window, search rotations from the oldest byte
    task automatic predict_status(input logic [7:0] rx, output status_word_t w);
        logic [63:0] echo;
        logic [2:0]  p;
        bit          hit;
        int          i;
        int          j;
        win_mem[win_ptr] = rx;
        win_ptr = win_ptr + 3'd1;
        hit = 1'b0;
        echo = '0;
        for (i = 0; i < 8 && !hit; i++) begin
            p = win_ptr + 3'(i);
            if (win_mem[p] == HDR_FIRST && win_mem[3'(p + 3'd1)] == HDR_SECOND) begin
                for (j = 0; j < 8; j++) echo = {echo[55:0], win_mem[3'(p + 3'(j))]};
                hit = 1'b1;
            end
        end
        if (hit) held_car = decode_command(echo);
        w.found    = hit;
        w.state    = held_car;
        w.dir_a    = pin_a;
        w.dir_b    = pin_b;
        w.duty     = duty_q;
        w.run      = run_q;
        w.echo     = hit ? echo : 64'd0;
        w.speed    = set_speed;
        w.distance = set_dist;
        w.angle    = set_angle;
    endtask

    // Status words that can be read straight off the frame layout
    function automatic bit typed_row(input int row, output status_word_t w);
        w.found    = 1'b0;
        w.state    = ST_FREE;
        w.dir_a    = DIR_IDLE;
        w.dir_b    = DIR_IDLE;
        w.duty     = 8'd0;
        w.run      = 1'b0;
        w.echo     = 64'd0;
        w.speed    = SPEED_RST;
        w.distance = DISTANCE_RST;
        w.angle    = ANGLE_RST;
        case (row)
            0: return 1'b1;
            7: begin
                w.found = 1'b1; w.state = ST_ON; w.run = 1'b1;
                w.echo = 64'hFFAA_0101_0100_FEEF;
                return 1'b1;
            end
            15: begin
                w.found = 1'b1; w.state = ST_SPEED; w.run = 1'b1;
                w.echo = 64'hFFAA_0401_FF00_FEEF; w.speed = 8'hFF;
                return 1'b1;
            end
            23: begin
                w.found = 1'b1; w.state = ST_FRONT; w.run = 1'b1;
                w.dir_a = DIR_FWD; w.dir_b = DIR_FWD; w.duty = 8'hFF;
                w.echo = 64'hFFAA_0201_0100_FEEF; w.speed = 8'hFF;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_row(input logic [7:0] rx);
        rx_row_t r;
        r.rx = rx;
        r.typed = 1'b0;
        rx_plan.push_back(r);
    endtask

    // Mostly well-formed frames with random content, some broken or cut short
    task automatic add_random_frame();
        logic [7:0] fr [0:7];
        int         n;
        int         k;
        fr[0] = HDR_FIRST;
        fr[1] = HDR_SECOND;
        fr[2] = ($urandom_range(99) < 88) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(255));
        fr[3] = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 4))
                                          : 8'($urandom_range(5, 255));
        for (k = 4; k < 6; k++)
            fr[k] = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 6))
                                              : 8'($urandom_range(255));
        fr[6] = TRL_FIRST;
        fr[7] = TRL_SECOND;
        if ($urandom_range(99) < 8) fr[6 + $urandom_range(1)] = 8'($urandom_range(255));
        n = ($urandom_range(99) < 10) ? $urandom_range(2, 7) : 8;
        for (k = 0; k < n; k++) add_row(fr[k]);
    endtask

    task automatic add_noise();
        int n;
        int k;
        int r;
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 20) add_row(HDR_FIRST);
            else if (r < 40) add_row(HDR_SECOND);
            else add_row(8'($urandom_range(255)));
        end
    endtask

    task automatic build_plan();
        rx_row_t r;
        int      row;
        // Walk the directed table first
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            r.rx = DIRECTED_RX[row];
            r.typed = typed_row(row, r.want);
            rx_plan.push_back(r);
        end
        while (rx_plan.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
            if ($urandom_range(99) < 80) add_random_frame();
            else add_noise();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH word %0d %s: got %h want %h", checked_words, what, got, want);
    endtask

    task automatic check_status(input status_word_t want);
        if (m_frame_found !== want.found)
            report_mismatch("frame_found", 64'(m_frame_found), 64'(want.found));
        if (m_car_state !== want.state)
            report_mismatch("car_state", 64'(m_car_state), 64'(want.state));
        if (m_motor_a_dir !== want.dir_a)
            report_mismatch("motor_a_dir", 64'(m_motor_a_dir), 64'(want.dir_a));
        if (m_motor_b_dir !== want.dir_b)
            report_mismatch("motor_b_dir", 64'(m_motor_b_dir), 64'(want.dir_b));
        if (m_pwm_duty !== want.duty)
            report_mismatch("pwm_duty", 64'(m_pwm_duty), 64'(want.duty));
        if (m_pwm_running !== want.run)
            report_mismatch("pwm_running", 64'(m_pwm_running), 64'(want.run));
        if (m_echo_frame !== want.echo) report_mismatch("echo_frame", m_echo_frame, want.echo);
        if (m_speed_value !== want.speed)
            report_mismatch("speed_value", 64'(m_speed_value), 64'(want.speed));
        if (m_distance_value !== want.distance)
            report_mismatch("distance_value", 64'(m_distance_value), 64'(want.distance));
        if (m_angle_value !== want.angle)
            report_mismatch("angle_value", 64'(m_angle_value), 64'(want.angle));
    endtask

    // Check outgoing words first, then predict the word for an accepted byte
    always @(posedge aclk) begin
        status_word_t pred;
        if (aresetn && m_valid && m_ready) begin
            if (status_queue.size() == 0) begin
                report_mismatch("unexpected word", m_echo_frame, 64'd0);
            end else begin
                check_status(status_queue.pop_front());
            end
            if (m_frame_found === 1'b1) found_words++;
            if (m_car_state !== 4'bx) states_seen[m_car_state] = 1'b1;
            checked_words++;
        end
        if (aresetn && s_valid && s_ready) begin
            predict_status(s_rx_byte, pred);
            if (rx_plan[accepted_bytes].typed) status_queue.push_back(rx_plan[accepted_bytes].want);
            else status_queue.push_back(pred);
            accepted_bytes++;
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
                     status_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off so the block fills up
    initial begin
        int hold;
        bit held_once;
        held_once = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held_once && accepted_bytes >= HOLDOFF_AT) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                for (hold = 0; hold < HOLDOFF_LEN; hold++) @(negedge aclk);
            end
            m_ready <= in_quiet_stretch() || $urandom_range(99) >= 13;
        end
    end

    // Sender: reset, then offer every planned byte
    initial begin
        int i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'd0;
        win_ptr = 3'd0;
        for (i = 0; i < 8; i++) win_mem[i] = 8'd0;
        held_car = ST_FREE;
        set_speed = SPEED_RST;
        set_dist = DISTANCE_RST;
        set_angle = ANGLE_RST;
        pin_a = DIR_IDLE;
        pin_b = DIR_IDLE;
        duty_q = 8'd0;
        run_q = 1'b0;
        build_plan();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < rx_plan.size(); i++) begin
            @(negedge aclk);
            // Idle gap: drop valid for a random number of cycles
            while (!in_quiet_stretch() && $urandom_range(99) < 13) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_rx_byte <= rx_plan[i].rx;
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding words, then watch for strays
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes, checked %0d status words, %0d carried a found frame.",
                 accepted_bytes, checked_words, found_words);
        $display("Saw %0d distinct car states; receiver held off %0d cycles once.",
                 $countones(states_seen), HOLDOFF_LEN);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ucfd_pkg.sv
hw/rtl/ucfd_ctrl.sv
hw/rtl/ucfd_dp.sv
hw/rtl/uart_command_frame_decoder_unit.sv
tb/uart_command_frame_decoder_unit_tb.sv
